### design/gdps_pkg.sv
`default_nettype none

package gdps_pkg;

   // grid geometry
   localparam int GRID_DIM   = 8;
   localparam int COORD_W    = 3;
   localparam int CELL_W     = 2 * COORD_W;
   localparam int CELL_COUNT = GRID_DIM * GRID_DIM;
   localparam int COUNT_W    = CELL_W + 1;
   localparam int MAX_OUT    = 63;

   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_DIM - 1);

   // item commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // neighbour directions, in visiting order
   localparam logic [1:0] DIR_Y_PLUS  = 2'd0;
   localparam logic [1:0] DIR_Y_MINUS = 2'd1;
   localparam logic [1:0] DIR_X_PLUS  = 2'd2;
   localparam logic [1:0] DIR_X_MINUS = 2'd3;

   typedef struct packed {
      logic               cmd;
      logic [2:0]         row_index;
      logic [7:0]         row_walls;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] goal_x;
      logic [COORD_W-1:0] goal_y;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] step_x;
      logic [COORD_W-1:0] step_y;
      logic               found;
      logic               empty_path;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

### design/grid_dfs_path_search.sv
`default_nettype none

// channel   ports                               direction   moves
// req       req_valid req_ready req_data        in          load or search item
// rsp       rsp_valid rsp_ready rsp_data        out         one path cell item
//
// a load item is taken in ST_IDLE; a search expands each cell with four
// neighbour checks, a stack read and a pop, traces each path cell with a
// parent read and a step back, and emits each cell with a path read and an
// output write; there are at most 65 expansions and 63 emitted path cells
// the single neighbour check unit and the single-read stack, parent and path
// memories set this pacing; req_ready is low for the whole search
// reset is synchronous and clears walls, counters, visited map and output valid
// a stalled rsp holds the sequencer in its emit step, nothing is dropped

module grid_dfs_path_search (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  gdps_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output gdps_pkg::rsp_type   rsp_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_EXPAND    = 3'd1;
   localparam logic [2:0] ST_CHECK     = 3'd2;
   localparam logic [2:0] ST_POP       = 3'd3;
   localparam logic [2:0] ST_TRACE_CHK = 3'd4;
   localparam logic [2:0] ST_TRACE_USE = 3'd5;
   localparam logic [2:0] ST_EMIT_RD   = 3'd6;
   localparam logic [2:0] ST_EMIT_OUT  = 3'd7;

   localparam int CW = gdps_pkg::COORD_W;
   localparam int IW = gdps_pkg::CELL_W;
   localparam int NW = gdps_pkg::COUNT_W;
   localparam int GD = gdps_pkg::GRID_DIM;
   localparam int CC = gdps_pkg::CELL_COUNT;

   logic [2:0]     state_ff, state_in;
   logic [1:0]     dir_ff, dir_in;
   logic [CW-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CW-1:0]  start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [CW-1:0]  goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [NW-1:0]  cnt_ff, cnt_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [IW-1:0]  rp_ff, rp_in;
   logic [IW-1:0]  e_ff, e_in;
   logic [CC-1:0]  visited_ff, visited_in;
   logic [7:0]     wall_ff [GD];
   logic [7:0]     wall_in [GD];
   logic           rsp_valid_ff, rsp_valid_in;
   gdps_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // memories: one write and one registered read each
   logic [IW-1:0]  stack_mem [CC];
   logic [1:0]     parent_mem [CC];
   logic [IW-1:0]  path_mem [CC];

   logic           stack_we, stack_re, parent_we, parent_re, path_we, path_re;
   logic [IW-1:0]  stack_wa, stack_ra, parent_wa, parent_ra, path_wa, path_ra;
   logic [IW-1:0]  stack_wd, path_wd;
   logic [1:0]     parent_wd;
   logic [IW-1:0]  stack_rd_ff, path_rd_ff;
   logic [1:0]     parent_rd_ff;

   // neighbour check unit
   logic           nbr_in_grid;
   logic [CW-1:0]  nbr_x, nbr_y;
   logic [IW-1:0]  nbr_idx;
   logic           nbr_ok;

   logic           req_accept;
   logic           out_free;
   logic [NW-1:0]  cnt_dec;
   logic [NW-1:0]  n_dec;
   logic [IW-1:0]  emit_count;
   logic           emit_last;

   assign req_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign cnt_dec    = cnt_ff - NW'(1);
   assign n_dec      = n_ff - NW'(1);
   // at most MAX_OUT cells leave the block
   assign emit_count = n_ff[NW-1] ? IW'(gdps_pkg::MAX_OUT) : n_ff[IW-1:0];
   assign emit_last  = (e_ff == (emit_count - IW'(1)));

   // candidate neighbour of the current cell for direction dir_ff
   always_comb begin
      nbr_x       = cur_x_ff;
      nbr_y       = cur_y_ff;
      nbr_in_grid = 1'b0;
      case (dir_ff)
         gdps_pkg::DIR_Y_PLUS: begin
            nbr_in_grid = (cur_y_ff != gdps_pkg::COORD_MAX);
            nbr_y       = cur_y_ff + CW'(1);
         end
         gdps_pkg::DIR_Y_MINUS: begin
            nbr_in_grid = (cur_y_ff != '0);
            nbr_y       = cur_y_ff - CW'(1);
         end
         gdps_pkg::DIR_X_PLUS: begin
            nbr_in_grid = (cur_x_ff != gdps_pkg::COORD_MAX);
            nbr_x       = cur_x_ff + CW'(1);
         end
         gdps_pkg::DIR_X_MINUS: begin
            nbr_in_grid = (cur_x_ff != '0);
            nbr_x       = cur_x_ff - CW'(1);
         end
         default: begin
            nbr_in_grid = 1'b0;
         end
      endcase
      nbr_idx = {nbr_y, nbr_x};
      nbr_ok  = nbr_in_grid && !wall_ff[nbr_y][nbr_x] && !visited_ff[nbr_idx];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      rp_in        = rp_ff;
      e_in         = e_ff;
      visited_in   = visited_ff;
      wall_in      = wall_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      stack_we  = 1'b0;
      stack_wa  = cnt_ff[IW-1:0];
      stack_wd  = nbr_idx;
      stack_re  = 1'b0;
      stack_ra  = cnt_dec[IW-1:0];
      parent_we = 1'b0;
      parent_wa = nbr_idx;
      parent_wd = dir_ff;
      parent_re = 1'b0;
      parent_ra = {cur_y_ff, cur_x_ff};
      path_we   = 1'b0;
      path_wa   = n_ff[IW-1:0];
      path_wd   = {cur_y_ff, cur_x_ff};
      path_re   = 1'b0;
      path_ra   = rp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.cmd == gdps_pkg::CMD_LOAD) begin
                  wall_in[req_data.row_index] = req_data.row_walls;
               end else begin
                  start_x_in = req_data.start_x;
                  start_y_in = req_data.start_y;
                  goal_x_in  = req_data.goal_x;
                  goal_y_in  = req_data.goal_y;
                  if ((req_data.start_x == req_data.goal_x) &&
                      (req_data.start_y == req_data.goal_y)) begin
                     // start on goal: single flagged item
                     rsp_valid_in           = 1'b1;
                     rsp_data_in.step_x     = req_data.goal_x;
                     rsp_data_in.step_y     = req_data.goal_y;
                     rsp_data_in.found      = 1'b1;
                     rsp_data_in.empty_path = 1'b1;
                     rsp_data_in.last       = 1'b1;
                  end else begin
                     // start is left unmarked on purpose
                     visited_in = '0;
                     cnt_in     = '0;
                     cur_x_in   = req_data.start_x;
                     cur_y_in   = req_data.start_y;
                     dir_in     = gdps_pkg::DIR_Y_PLUS;
                     state_in   = ST_EXPAND;
                  end
               end
            end
         end
         ST_EXPAND: begin
            // one neighbour a cycle
            if (nbr_ok) begin
               visited_in[nbr_idx] = 1'b1;
               parent_we           = 1'b1;
               if (!cnt_ff[NW-1]) begin
                  stack_we = 1'b1;
                  cnt_in   = cnt_ff + NW'(1);
               end
            end
            dir_in = dir_ff + 2'd1;
            if (dir_ff == gdps_pkg::DIR_X_MINUS) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cnt_ff == '0) begin
               // stack ran dry: no path
               rsp_valid_in           = 1'b1;
               rsp_data_in.step_x     = '0;
               rsp_data_in.step_y     = '0;
               rsp_data_in.found      = 1'b0;
               rsp_data_in.empty_path = 1'b0;
               rsp_data_in.last       = 1'b1;
               state_in               = ST_IDLE;
            end else begin
               cnt_in   = cnt_dec;
               stack_re = 1'b1;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            cur_x_in = stack_rd_ff[CW-1:0];
            cur_y_in = stack_rd_ff[IW-1:CW];
            if ((stack_rd_ff[CW-1:0] == goal_x_ff) &&
                (stack_rd_ff[IW-1:CW] == goal_y_ff)) begin
               n_in     = '0;
               state_in = ST_TRACE_CHK;
            end else begin
               dir_in   = gdps_pkg::DIR_Y_PLUS;
               state_in = ST_EXPAND;
            end
         end
         ST_TRACE_CHK: begin
            if (((cur_x_ff == start_x_ff) && (cur_y_ff == start_y_ff)) || n_ff[NW-1]) begin
               rp_in    = n_dec[IW-1:0];
               e_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               parent_re = 1'b1;
               state_in  = ST_TRACE_USE;
            end
         end
         ST_TRACE_USE: begin
            // store cell, then step back towards its parent
            path_we = 1'b1;
            n_in    = n_ff + NW'(1);
            case (parent_rd_ff)
               gdps_pkg::DIR_Y_PLUS:  cur_y_in = cur_y_ff - CW'(1);
               gdps_pkg::DIR_Y_MINUS: cur_y_in = cur_y_ff + CW'(1);
               gdps_pkg::DIR_X_PLUS:  cur_x_in = cur_x_ff - CW'(1);
               gdps_pkg::DIR_X_MINUS: cur_x_in = cur_x_ff + CW'(1);
               default:               cur_x_in = cur_x_ff;
            endcase
            state_in = ST_TRACE_CHK;
         end
         ST_EMIT_RD: begin
            path_re  = 1'b1;
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            // path buffer is read backwards: start side first
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.step_x     = path_rd_ff[CW-1:0];
               rsp_data_in.step_y     = path_rd_ff[IW-1:CW];
               rsp_data_in.found      = 1'b1;
               rsp_data_in.empty_path = 1'b0;
               rsp_data_in.last       = emit_last;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rp_in    = rp_ff - IW'(1);
                  e_in     = e_ff + IW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         n_ff         <= '0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < GD; i++) begin
            wall_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
         wall_ff      <= wall_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      start_x_ff  <= start_x_in;
      start_y_ff  <= start_y_in;
      goal_x_ff   <= goal_x_in;
      goal_y_ff   <= goal_y_in;
      rp_ff       <= rp_in;
      e_ff        <= e_in;
      rsp_data_ff <= rsp_data_in;
   end

   // search stack
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_ra];
      end
   end

   // parent directions
   always_ff @(posedge clock) begin
      if (parent_we) begin
         parent_mem[parent_wa] <= parent_wd;
      end
      if (parent_re) begin
         parent_rd_ff <= parent_mem[parent_ra];
      end
   end

   // traced path, goal first
   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[path_wa] <= path_wd;
      end
      if (path_re) begin
         path_rd_ff <= path_mem[path_ra];
      end
   end

   // stack never holds more than the cell count
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(CC))
      else $error("stack count overflow");

   // a search item either starts the sequencer or answers at once
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.cmd == gdps_pkg::CMD_SEARCH)) |=>
         ((state_ff != ST_IDLE) || rsp_valid_ff))
      else $error("search item left no trace");

   // empty path item is always a found, final item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.empty_path) |->
         (rsp_data_ff.found && rsp_data_ff.last))
      else $error("empty path item malformed");

   // no-path item is final and at the origin
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |->
         (rsp_data_ff.last && (rsp_data_ff.step_x == '0) && (rsp_data_ff.step_y == '0)))
      else $error("no-path item malformed");

   // emit counter stays inside the path
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_OUT) |-> (e_ff < emit_count))
      else $error("emit counter past path end");

endmodule

`default_nettype wire
